FILE: rtl/core/rgb_to_hsv_converter_assert.svh
// Assertion macros shared by the RGB to HSV converter RTL.
`ifndef RGB_TO_HSV_CONVERTER_ASSERT_SVH
`define RGB_TO_HSV_CONVERTER_ASSERT_SVH

// Checks that a condition holds on every clock edge outside reset.
`define RHC_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error(msg);

// Checks that an antecedent implies a consequent on the same edge.
`define RHC_ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

FILE: rtl/core/rgbhsv_pkg.sv
// Types, constants and the divider step shared by the RGB to HSV converter.
`default_nettype none

package rgbhsv_pkg;

    // Hue constants in 1/64 degree
    localparam logic [14:0] HUE_GREEN = 15'd7680;
    localparam logic [14:0] HUE_BLUE  = 15'd15360;
    localparam logic [14:0] HUE_FULL  = 15'd23040;

    // Divider pipeline shape: 12 quotient bits, two per stage
    localparam int STEPS_PER_STAGE = 2;
    localparam int DIV_STAGES      = 6;

    typedef enum logic [1:0] {
        SECTOR_RED,
        SECTOR_GREEN,
        SECTOR_BLUE
    } sector_t;

    // Restoring divider state: partial remainder, numerator bits still
    // to shift in (MSB first), quotient built so far.
    typedef struct packed {
        logic [7:0]  rem;
        logic [11:0] num;
        logic [11:0] quo;
    } div_t;

    typedef struct packed {
        div_t       hue_div;
        div_t       sat_div;
        logic [7:0] delta;
        logic [7:0] vmax;
        sector_t    sector;
        logic       neg;
        logic       undef;
    } pipe_t;

    // One radix-2 restoring step; remainder stays below the divisor.
    function automatic div_t div_step(div_t s, logic [7:0] d);
        div_t       r;
        logic [8:0] t;
        r = s;
        t = {s.rem, s.num[11]};
        r.num = {s.num[10:0], 1'b0};
        if (t >= {1'b0, d})
        begin
            r.rem = 8'(t - {1'b0, d});
            r.quo = {s.quo[10:0], 1'b1};
        end
        else
        begin
            r.rem = t[7:0];
            r.quo = {s.quo[10:0], 1'b0};
        end
        return r;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/core/rgbhsv_prep.sv
// Front stage: max/min, sector pick, signed difference and divider setup.
`default_nettype none

module rgbhsv_prep (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              up_valid,
    output logic                   up_ready,
    input  wire logic [7:0]        red,
    input  wire logic [7:0]        green,
    input  wire logic [7:0]        blue,
    output logic                   dn_valid,
    input  wire logic              dn_ready,
    output rgbhsv_pkg::pipe_t      dn_pipe
);

    logic               valid_reg;
    rgbhsv_pkg::pipe_t  pipe_reg;
    rgbhsv_pkg::pipe_t  pipe_next;

    logic [7:0]  vmax;
    logic [7:0]  vmin;
    logic [7:0]  delta;
    logic [8:0]  diff;
    logic [8:0]  diff_neg;
    logic [7:0]  mag;
    logic [11:0] mag15;
    logic [15:0] sat_num;
    rgbhsv_pkg::sector_t sector;

    assign up_ready = !valid_reg || dn_ready;

    always_comb
    begin
        vmax = (red >= green) ? red : green;
        vmax = (vmax >= blue) ? vmax : blue;
        vmin = (red <= green) ? red : green;
        vmin = (vmin <= blue) ? vmin : blue;
        delta = vmax - vmin;

        // red wins ties, then green
        if (red >= green && red >= blue)
        begin
            sector = rgbhsv_pkg::SECTOR_RED;
        end
        else if (green >= blue)
        begin
            sector = rgbhsv_pkg::SECTOR_GREEN;
        end
        else
        begin
            sector = rgbhsv_pkg::SECTOR_BLUE;
        end

        case (sector)
            rgbhsv_pkg::SECTOR_RED:   diff = {1'b0, green} - {1'b0, blue};
            rgbhsv_pkg::SECTOR_GREEN: diff = {1'b0, blue} - {1'b0, red};
            rgbhsv_pkg::SECTOR_BLUE:  diff = {1'b0, red} - {1'b0, green};
            default:                  diff = 9'd0;
        endcase

        diff_neg = 9'd0 - diff;
        mag      = diff[8] ? diff_neg[7:0] : diff[7:0];
        // 3840 * mag = (15 * mag) << 8
        mag15    = ({4'd0, mag} << 4) - {4'd0, mag};
        // 255 * delta
        sat_num  = ({8'd0, delta} << 8) - {8'd0, delta};

        // top 8 numerator bits form the first remainder (below divisor)
        pipe_next.hue_div.rem = mag15[11:4];
        pipe_next.hue_div.num = {mag15[3:0], 8'd0};
        pipe_next.hue_div.quo = 12'd0;
        pipe_next.sat_div.rem = {4'd0, sat_num[15:12]};
        pipe_next.sat_div.num = sat_num[11:0];
        pipe_next.sat_div.quo = 12'd0;
        pipe_next.delta       = delta;
        pipe_next.vmax        = vmax;
        pipe_next.sector      = sector;
        pipe_next.neg         = diff[8];
        pipe_next.undef       = (delta == 8'd0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (up_ready)
        begin
            valid_reg <= up_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (up_ready && up_valid)
        begin
            pipe_reg <= pipe_next;
        end
    end

    assign dn_valid = valid_reg;
    assign dn_pipe  = pipe_reg;

endmodule

`default_nettype wire

FILE: rtl/core/rgbhsv_div_stage.sv
// Divider stage: two restoring steps on both the hue and saturation divisions.
`default_nettype none

module rgbhsv_div_stage (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              up_valid,
    output logic                   up_ready,
    input  wire rgbhsv_pkg::pipe_t up_pipe,
    output logic                   dn_valid,
    input  wire logic              dn_ready,
    output rgbhsv_pkg::pipe_t      dn_pipe
);

    logic               valid_reg;
    rgbhsv_pkg::pipe_t  pipe_reg;
    rgbhsv_pkg::pipe_t  pipe_next;

    assign up_ready = !valid_reg || dn_ready;

    always_comb
    begin
        pipe_next = up_pipe;
        for (int i = 0; i < rgbhsv_pkg::STEPS_PER_STAGE; i++)
        begin
            pipe_next.hue_div = rgbhsv_pkg::div_step(pipe_next.hue_div, up_pipe.delta);
            pipe_next.sat_div = rgbhsv_pkg::div_step(pipe_next.sat_div, up_pipe.vmax);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (up_ready)
        begin
            valid_reg <= up_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (up_ready && up_valid)
        begin
            pipe_reg <= pipe_next;
        end
    end

    assign dn_valid = valid_reg;
    assign dn_pipe  = pipe_reg;

endmodule

`default_nettype wire

FILE: rtl/core/rgbhsv_final.sv
// Output stage: sector offset, sign, wrap and the output register.
`default_nettype none

module rgbhsv_final (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              up_valid,
    output logic                   up_ready,
    input  wire rgbhsv_pkg::pipe_t up_pipe,
    output logic                   dn_valid,
    input  wire logic              dn_ready,
    output logic [14:0]            hue,
    output logic [7:0]             saturation,
    output logic [7:0]             value,
    output logic                   hue_undefined
);

    logic        valid_reg;
    logic [14:0] hue_reg;
    logic [14:0] hue_next;
    logic [7:0]  sat_reg;
    logic [7:0]  sat_next;
    logic [7:0]  value_reg;
    logic        undef_reg;

    logic [14:0] offset;
    logic [14:0] base;
    logic [14:0] quo;

    assign up_ready = !valid_reg || dn_ready;

    always_comb
    begin
        case (up_pipe.sector)
            rgbhsv_pkg::SECTOR_RED:   offset = 15'd0;
            rgbhsv_pkg::SECTOR_GREEN: offset = rgbhsv_pkg::HUE_GREEN;
            rgbhsv_pkg::SECTOR_BLUE:  offset = rgbhsv_pkg::HUE_BLUE;
            default:                  offset = 15'd0;
        endcase

        quo = {3'd0, up_pipe.hue_div.quo};
        // only the red sector can go negative; fold the wrap into the base
        base = (up_pipe.sector == rgbhsv_pkg::SECTOR_RED && up_pipe.neg)
             ? rgbhsv_pkg::HUE_FULL : offset;

        if (up_pipe.undef)
        begin
            hue_next = 15'd0;
            sat_next = 8'd0;
        end
        else
        begin
            hue_next = up_pipe.neg ? (base - quo) : (base + quo);
            sat_next = up_pipe.sat_div.quo[7:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (up_ready)
        begin
            valid_reg <= up_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (up_ready && up_valid)
        begin
            hue_reg   <= hue_next;
            sat_reg   <= sat_next;
            value_reg <= up_pipe.vmax;
            undef_reg <= up_pipe.undef;
        end
    end

    assign dn_valid      = valid_reg;
    assign hue           = hue_reg;
    assign saturation    = sat_reg;
    assign value         = value_reg;
    assign hue_undefined = undef_reg;

endmodule

`default_nettype wire

FILE: rtl/core/rgb_to_hsv_converter.sv
// Top level of the pipelined RGB to HSV pixel converter.
//
// Input channel (rgb_valid / rgb_stall): one beat is one pixel, red, green and
// blue, 8 bits each. A beat is taken on a rising edge with rgb_valid high and
// rgb_stall low.
// Output channel (hsv_valid / hsv_stall): one beat per pixel with hue in 1/64
// degree (0..23039), saturation (255 = 1.0), value (largest channel) and
// hue_undefined (all channels equal; hue and saturation are then 0).
// Pipeline: from the accepting edge to hsv_valid a beat passes the front
// stage, six divider stages (two quotient bits each, 12-bit hue quotient) and
// the output register.
// Throughput: one pixel per clock unless the output stalls; every stage has its own valid bit.
// Stall: a stage loads whenever it is empty or the next one moves, so bubbles
// close up behind a stalled output; rgb_stall rises only once every stage
// holds a beat. A stalled output beat holds steady.
// Reset: rst_n is asynchronous, active low, and empties the pipeline; no
// pixel state is kept between beats.
`default_nettype none

`include "rgb_to_hsv_converter_assert.svh"

module rgb_to_hsv_converter (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        rgb_valid,
    output logic             rgb_stall,
    input  wire logic [7:0]  red,
    input  wire logic [7:0]  green,
    input  wire logic [7:0]  blue,
    output logic             hsv_valid,
    input  wire logic        hsv_stall,
    output logic [14:0]      hue,
    output logic [7:0]       saturation,
    output logic [7:0]       value,
    output logic             hue_undefined
);

    localparam int NS = rgbhsv_pkg::DIV_STAGES;

    // stg_*[k] is the beat leaving stage k (k = 0 is the front stage);
    // stg_ready[k] says its consumer can take it.
    rgbhsv_pkg::pipe_t stg_pipe [NS+1];
    logic [NS:0]       stg_valid;
    logic [NS:0]       stg_ready;
    logic              prep_ready;

    rgbhsv_prep u_prep (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (rgb_valid),
        .up_ready (prep_ready),
        .red      (red),
        .green    (green),
        .blue     (blue),
        .dn_valid (stg_valid[0]),
        .dn_ready (stg_ready[0]),
        .dn_pipe  (stg_pipe[0])
    );

    // Divider chain: each stage retires two quotient bits of both divisions
    for (genvar k = 0; k < NS; k++)
    begin : g_div
        rgbhsv_div_stage u_div (
            .clk      (clk),
            .rst_n    (rst_n),
            .up_valid (stg_valid[k]),
            .up_ready (stg_ready[k]),
            .up_pipe  (stg_pipe[k]),
            .dn_valid (stg_valid[k+1]),
            .dn_ready (stg_ready[k+1]),
            .dn_pipe  (stg_pipe[k+1])
        );
    end

    rgbhsv_final u_final (
        .clk           (clk),
        .rst_n         (rst_n),
        .up_valid      (stg_valid[NS]),
        .up_ready      (stg_ready[NS]),
        .up_pipe       (stg_pipe[NS]),
        .dn_valid      (hsv_valid),
        .dn_ready      (!hsv_stall),
        .hue           (hue),
        .saturation    (saturation),
        .value         (value),
        .hue_undefined (hue_undefined)
    );

    assign rgb_stall = !prep_ready;

    // Gray pixels carry zero hue and saturation
    `RHC_ASSERT_IMPLY(a_undef_zero, hsv_valid && hue_undefined,
        hue == 15'd0 && saturation == 8'd0, "undefined hue with nonzero hue or saturation")

    // A colored pixel has nonzero value and saturation
    `RHC_ASSERT_IMPLY(a_colored_nonzero, hsv_valid && !hue_undefined,
        saturation != 8'd0 && value != 8'd0, "colored pixel with zero saturation or value")

    // Hue wraps into one turn
    `RHC_ASSERT_IMPLY(a_hue_range, hsv_valid, hue < rgbhsv_pkg::HUE_FULL,
        "hue out of range")

    // Input stalls only when every stage holds a beat
    `RHC_ASSERT_IMPLY(a_stall_full, rgb_stall, (&stg_valid) && hsv_valid && hsv_stall,
        "input stalled with a free pipeline slot")

endmodule

`default_nettype wire

FILE: sim/rgb_to_hsv_checker.sv
// Checker for the RGB to HSV converter: predicts each pixel and compares output beats.
`timescale 1ns / 100ps

module rgb_to_hsv_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        rgb_valid,
    input  logic        rgb_stall,
    input  logic [7:0]  red,
    input  logic [7:0]  green,
    input  logic [7:0]  blue,
    input  logic        hsv_valid,
    input  logic        hsv_stall,
    input  logic [14:0] hue,
    input  logic [7:0]  saturation,
    input  logic [7:0]  value,
    input  logic        hue_undefined,
    output int          error_count,
    output int          pending
);

    localparam int HUE_SECTOR = 3840;   // 60 degrees in 1/64 degree

    typedef struct packed {
        logic [14:0] hue;
        logic [7:0]  sat;
        logic [7:0]  val;
        logic        undef;
    } hsv_pixel_t;

    hsv_pixel_t pending_hsv[$];

    function automatic hsv_pixel_t rgb_to_hsv(input logic [7:0] r, input logic [7:0] g,
                                              input logic [7:0] b);
        hsv_pixel_t           px;
        rgbhsv_pkg::sector_t  sec;
        int         ri;
        int         gi;
        int         bi;
        int         mx;
        int         mn;
        int         span;
        int         h;
        ri = r;
        gi = g;
        bi = b;
        // red wins ties, then green
        mx  = ri;
        sec = rgbhsv_pkg::SECTOR_RED;
        if (gi > mx)
        begin
            mx  = gi;
            sec = rgbhsv_pkg::SECTOR_GREEN;
        end
        if (bi > mx)
        begin
            mx  = bi;
            sec = rgbhsv_pkg::SECTOR_BLUE;
        end
        mn = (ri < gi) ? ri : gi;
        mn = (bi < mn) ? bi : mn;
        span = mx - mn;
        px.val = mx[7:0];
        if (span == 0)
        begin
            px.undef = 1'b1;
            px.hue   = '0;
            px.sat   = '0;
        end
        else
        begin
            px.undef = 1'b0;
            px.sat   = 8'((255 * span) / mx);
            // int division truncates toward zero
            case (sec)
                rgbhsv_pkg::SECTOR_RED:
                    h = (HUE_SECTOR * (gi - bi)) / span;
                rgbhsv_pkg::SECTOR_GREEN:
                    h = int'(rgbhsv_pkg::HUE_GREEN) + (HUE_SECTOR * (bi - ri)) / span;
                default:
                    h = int'(rgbhsv_pkg::HUE_BLUE) + (HUE_SECTOR * (ri - gi)) / span;
            endcase
            if (h < 0)
                h = h + int'(rgbhsv_pkg::HUE_FULL);
            px.hue = 15'(h);
        end
        return px;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : monitor
        hsv_pixel_t want;
        int         bad;
        if (!rst_n)
        begin
            pending_hsv.delete();
            error_count <= 0;
            pending     <= 0;
        end
        else
        begin
            bad = 0;
            if (hsv_valid && !hsv_stall)
            begin
                if (pending_hsv.size() == 0)
                begin
                    $error("hsv beat with no pixel outstanding");
                    bad++;
                end
                else
                begin
                    want = pending_hsv.pop_front();
                    if (hue !== want.hue)
                    begin
                        $error("hue: expected %0d, actual %0d", want.hue, hue);
                        bad++;
                    end
                    if (saturation !== want.sat)
                    begin
                        $error("saturation: expected %0d, actual %0d", want.sat, saturation);
                        bad++;
                    end
                    if (value !== want.val)
                    begin
                        $error("value: expected %0d, actual %0d", want.val, value);
                        bad++;
                    end
                    if (hue_undefined !== want.undef)
                    begin
                        $error("hue_undefined: expected %0b, actual %0b",
                               want.undef, hue_undefined);
                        bad++;
                    end
                end
            end
            if (rgb_valid && !rgb_stall)
                pending_hsv.push_back(rgb_to_hsv(red, green, blue));
            error_count <= error_count + bad;
            pending     <= pending_hsv.size();
        end
    end

endmodule

FILE: sim/tb_rgb_to_hsv_converter.sv
// Testbench top for the RGB to HSV converter: clock, reset, pixel stimulus and verdict.
`timescale 1ns / 100ps

module tb_rgb_to_hsv_converter;

    localparam int RANDOM_PIXELS = 1530;
    localparam int QUIET_TAIL    = 200;   // last pixels sent with no idling on either side
    localparam int DRAIN_CYCLES  = 20;    // pipeline is 8 deep, leave margin
    localparam int IDLE_LIMIT    = 5000;  // cycles with no beat on either channel

    logic        clk;
    logic        rst_n;
    logic        rgb_valid;
    logic        rgb_stall;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic        hsv_valid;
    logic        hsv_stall;
    logic [14:0] hue;
    logic [7:0]  saturation;
    logic [7:0]  value;
    logic        hue_undefined;

    int          error_count;
    int          pending;
    int          idle_cycles;

    // Burst enables; the pixel sender flips these by phase.
    bit          src_bursts;
    bit          snk_bursts;

    rgb_to_hsv_converter u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .rgb_valid     (rgb_valid),
        .rgb_stall     (rgb_stall),
        .red           (red),
        .green         (green),
        .blue          (blue),
        .hsv_valid     (hsv_valid),
        .hsv_stall     (hsv_stall),
        .hue           (hue),
        .saturation    (saturation),
        .value         (value),
        .hue_undefined (hue_undefined)
    );

    rgb_to_hsv_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .rgb_valid     (rgb_valid),
        .rgb_stall     (rgb_stall),
        .red           (red),
        .green         (green),
        .blue          (blue),
        .hsv_valid     (hsv_valid),
        .hsv_stall     (hsv_stall),
        .hue           (hue),
        .saturation    (saturation),
        .value         (value),
        .hue_undefined (hue_undefined),
        .error_count   (error_count),
        .pending       (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Watchdog: a hang shows up as a long run of cycles with no beat on
    // either channel, including an output beat that never arrives.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            idle_cycles <= 0;
        else if ((rgb_valid && !rgb_stall) || (hsv_valid && !hsv_stall))
            idle_cycles <= 0;
        else if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    // Output side: random stall bursts while enabled.
    // Stall changes only at the falling edge, and each burst is followed
    // by an unstalled stretch so the two NBAs never share a step.
    initial
    begin
        hsv_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (snk_bursts && $urandom_range(0, 5) == 0)
            begin
                hsv_stall <= 1'b1;
                repeat ($urandom_range(1, 11)) @(negedge clk);
                hsv_stall <= 1'b0;
            end
        end
    end

    // Present one pixel and hold it until the converter takes the beat.
    // Entered and left at a falling edge. During an idle burst the payload
    // wanders so a beat taken while valid is low would show up as an
    // extra output beat.
    task automatic send_pixel(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
        if (src_bursts && $urandom_range(0, 4) == 0)
        begin
            rgb_valid <= 1'b0;
            repeat ($urandom_range(1, 11))
            begin
                red   <= 8'($urandom);
                green <= 8'($urandom);
                blue  <= 8'($urandom);
                @(negedge clk);
            end
        end
        rgb_valid <= 1'b1;
        red       <= r;
        green     <= g;
        blue      <= b;
        @(posedge clk);
        while (rgb_stall)
            @(posedge clk);
        @(negedge clk);
    endtask

    initial
    begin : stimulus
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
        int         i;

        rst_n      = 1'b0;
        rgb_valid  = 1'b0;
        red        = '0;
        green      = '0;
        blue       = '0;
        src_bursts = 1'b0;
        snk_bursts = 1'b0;

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed pixels, no idling.
        // Gray levels: hue undefined, black included.
        send_pixel(8'd0,   8'd0,   8'd0);
        send_pixel(8'd255, 8'd255, 8'd255);
        send_pixel(8'd128, 8'd128, 8'd128);
        send_pixel(8'd1,   8'd1,   8'd1);
        // Pure primaries, one per sector.
        send_pixel(8'd255, 8'd0,   8'd0);
        send_pixel(8'd0,   8'd255, 8'd0);
        send_pixel(8'd0,   8'd0,   8'd255);
        // Ties for the largest channel: red beats green and blue,
        // green beats blue.
        send_pixel(8'd255, 8'd255, 8'd0);
        send_pixel(8'd255, 8'd0,   8'd255);
        send_pixel(8'd0,   8'd255, 8'd255);
        send_pixel(8'd1,   8'd1,   8'd0);
        // Smallest nonzero spans.
        send_pixel(8'd1,   8'd0,   8'd0);
        send_pixel(8'd0,   8'd1,   8'd0);
        send_pixel(8'd0,   8'd0,   8'd1);
        send_pixel(8'd255, 8'd254, 8'd254);
        // Red sector with blue over green: negative hue wraps around.
        send_pixel(8'd255, 8'd0,   8'd1);
        send_pixel(8'd200, 8'd100, 8'd150);
        // Assorted hues, truncation toward zero in both directions.
        send_pixel(8'd254, 8'd255, 8'd253);
        send_pixel(8'd10,  8'd200, 8'd199);
        send_pixel(8'd37,  8'd12,  8'd240);
        send_pixel(8'd1,   8'd2,   8'd3);
        send_pixel(8'd170, 8'd85,  8'd0);
        send_pixel(8'd3,   8'd2,   8'd1);

        // Random pixels. Idling comes and goes in phases of 150 pixels and
        // is off for the quiet tail so the pipeline also runs full rate.
        for (i = 0; i < RANDOM_PIXELS; i++)
        begin
            src_bursts = (i < RANDOM_PIXELS - QUIET_TAIL) && ((i / 150) % 3 != 2);
            snk_bursts = (i < RANDOM_PIXELS - QUIET_TAIL) && ((i / 150) % 3 != 1);
            r = 8'($urandom_range(0, 255));
            g = 8'($urandom_range(0, 255));
            b = 8'($urandom_range(0, 255));
            case ($urandom_range(0, 19))
                14, 15:
                begin
                    // two channels equal, max or min
                    case ($urandom_range(0, 2))
                        0:       g = r;
                        1:       b = r;
                        default: b = g;
                    endcase
                end
                16:
                begin
                    g = r;
                    b = r;
                end
                17, 18, 19:
                begin
                    // near-gray: tiny spans stress the dividers
                    g = r ^ 8'($urandom_range(0, 3));
                    b = r ^ 8'($urandom_range(0, 3));
                end
                default:
                begin
                end
            endcase
            send_pixel(r, g, b);
        end
        src_bursts = 1'b0;
        snk_bursts = 1'b0;
        rgb_valid <= 1'b0;

        // Drain: wait for every predicted pixel, then watch for strays.
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (error_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
